// File: rtl/core/rtf_pkg.sv
// Shared types and constants for the ring twinkle frame generator.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps

package rtf_pkg;

    localparam int RING_MAX_DEF = 32;
    localparam int FACE_MAX_DEF = 32;

    localparam int RAND_W = 32;
    localparam int STEP_W = $clog2(RAND_W + 1);
    localparam int CNT_W  = 6;
    localparam int LIFE_W = 6;
    localparam int CHAN_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [LIFE_W-1:0] LIFE_START  = LIFE_W'(48);
    localparam logic [LIFE_W-1:0] WHITE_ABOVE = LIFE_W'(40);
    localparam logic [CHAN_W-1:0] CHAN_FULL   = CHAN_W'(255);

    // ring_count / 3 as (x * 171) >> 9, exact for x < 64
    localparam int THIRD_MUL   = 171;
    localparam int THIRD_SHIFT = 9;

    localparam logic [CNT_W-1:0] RING_COUNT_RST = CNT_W'(24);
    localparam logic [CNT_W-1:0] FACE_COUNT_RST = CNT_W'(8);
    localparam logic [CHAN_W-1:0] BRIGHT_RST    = CHAN_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_COUNT = 3'd0,
        REG_FACE_COUNT = 3'd1,
        REG_RING_FIRST = 3'd2,
        REG_BRIGHTNESS = 3'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_WAIT_MOD,
        ST_SPAWN_RD,
        ST_SPAWN_WR,
        ST_RING_RD,
        ST_RING_CALC,
        ST_RING_OUT,
        ST_FACE
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  pixel_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } pix_req_t;

endpackage

// File: rtl/core/ring_twinkle_frame_generator.sv
// Ring twinkle frame generator: per-frame spark spawn, ring and face pixel stream.
// Top level; holds the spark life memory and sequencer. Depends on rtf_pkg,
// rtf_mod_unit and rtf_pixel_out.
//
// One beat on s_ is one frame tick; it yields ring_count + face_count pixel beats on
// m_, the last flagged by m_frame_end. The spark countdowns live in a synchronous
// memory with one read and one write port, so the frame is walked one entry at a
// time: a count pass over the ring entries overlapped with the serial remainder
// units for the two random words, up to two spawn read/write pairs, a read, a
// calculate and an output state per ring pixel for the read-modify-write of its
// countdown, and one face pixel per cycle while m_ready does not stall the output.
// After reset a clearing pass over all RING_MAX entries zeroes the memory before
// the first tick is taken; configuration writes are accepted at any time but must
// only be made between frames.
`timescale 1ns / 1ps

module ring_twinkle_frame_generator #(
    parameter int RING_MAX = rtf_pkg::RING_MAX_DEF,
    parameter int FACE_MAX = rtf_pkg::FACE_MAX_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtf_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rtf_pkg::RAND_W-1:0]     s_spawn_rand_first,
    input  logic [rtf_pkg::RAND_W-1:0]     s_spawn_rand_second,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rtf_pkg::CNT_W-1:0]      m_pixel_index,
    output logic [rtf_pkg::CHAN_W-1:0]     m_red,
    output logic [rtf_pkg::CHAN_W-1:0]     m_green,
    output logic [rtf_pkg::CHAN_W-1:0]     m_blue,
    output logic                           m_frame_end
);

    localparam int AW = $clog2(RING_MAX);
    localparam int CW = rtf_pkg::CNT_W;
    localparam int LW = rtf_pkg::LIFE_W;
    localparam int HW = rtf_pkg::CHAN_W;
    localparam logic [CW-1:0] RING_LIM = CW'(RING_MAX);
    localparam logic [CW-1:0] FACE_LIM = CW'(FACE_MAX);

    // configuration
    logic [CW-1:0] ring_count_reg;
    logic [CW-1:0] face_count_reg;
    logic          ring_first_reg;
    logic [HW-1:0] brightness_reg;
    logic [CW-1:0] cfg_val;
    logic [CW-1:0] cap;
    logic [CW+8:0] third_prod;

    assign cfg_ready = 1'b1;
    assign cfg_val   = cfg_data[CW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_count_reg <= rtf_pkg::RING_COUNT_RST;
            face_count_reg <= rtf_pkg::FACE_COUNT_RST;
            ring_first_reg <= 1'b1;
            brightness_reg <= rtf_pkg::BRIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rtf_pkg::REG_RING_COUNT: begin
                    if (cfg_val == '0) begin
                        ring_count_reg <= CW'(1);
                    end else if (cfg_val > RING_LIM) begin
                        ring_count_reg <= RING_LIM;
                    end else begin
                        ring_count_reg <= cfg_val;
                    end
                end
                rtf_pkg::REG_FACE_COUNT: begin
                    face_count_reg <= (cfg_val > FACE_LIM) ? FACE_LIM : cfg_val;
                end
                rtf_pkg::REG_RING_FIRST: ring_first_reg <= cfg_data[0];
                rtf_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    assign third_prod = {9'd0, ring_count_reg} * (CW+9)'(rtf_pkg::THIRD_MUL);
    assign cap        = CW'(third_prod >> rtf_pkg::THIRD_SHIFT);

    // remainder units
    logic          s_take;
    logic          mod0_done;
    logic          mod1_done;
    logic [CW-1:0] mod0_rem;
    logic [CW-1:0] mod1_rem;

    rtf_mod_unit u_mod0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_take),
        .dividend (s_spawn_rand_first),
        .divisor  (ring_count_reg),
        .done     (mod0_done),
        .rem      (mod0_rem)
    );

    rtf_mod_unit u_mod1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_take),
        .dividend (s_spawn_rand_second),
        .divisor  (ring_count_reg),
        .done     (mod1_done),
        .rem      (mod1_rem)
    );

    // spark life memory
    logic [LW-1:0] life_mem [RING_MAX];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [LW-1:0] mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            life_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= life_mem[mem_raddr];
    end

    // sequencer
    rtf_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     fcnt_reg, fcnt_next;
    logic [CW-1:0]     live_reg, live_next;
    logic              sel_reg, sel_next;
    logic              rd_pend_reg, rd_pend_next;
    rtf_pkg::pix_req_t pix_reg, pix_next;
    rtf_pkg::pix_req_t req;
    logic              req_valid;
    logic              req_take;

    logic [CW-1:0]     spawn_idx;
    logic [CW:0]       ring_pos_sum;
    logic [CW:0]       face_pos_sum;
    logic [CW-1:0]     ring_pos;
    logic [CW-1:0]     face_pos;
    logic              ring_last;
    logic              face_last;
    logic [LW+2:0]     green_prod;
    logic [LW+5:0]     blue_prod;

    assign s_ready   = (state_reg == rtf_pkg::ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign spawn_idx = sel_reg ? mod1_rem : mod0_rem;

    assign ring_pos_sum = {1'b0, face_count_reg} + {1'b0, cnt_reg};
    assign face_pos_sum = {1'b0, ring_count_reg} + {1'b0, fcnt_reg};
    assign ring_pos     = ring_first_reg ? cnt_reg : ring_pos_sum[CW-1:0];
    assign face_pos     = ring_first_reg ? face_pos_sum[CW-1:0] : fcnt_reg;
    assign ring_last    = (cnt_reg + CW'(1)) == ring_count_reg;
    assign face_last    = (fcnt_reg + CW'(1)) == face_count_reg;

    // green 70*life/40 = 7*life/4, blue 255*life/40 = 51*life/8
    assign green_prod = (LW+3)'(mem_rdata_reg) * (LW+3)'(7);
    assign blue_prod  = (LW+6)'(mem_rdata_reg) * (LW+6)'(51);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rtf_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            fcnt_reg    <= '0;
            live_reg    <= '0;
            sel_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            fcnt_reg    <= fcnt_next;
            live_reg    <= live_next;
            sel_reg     <= sel_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        fcnt_next    = fcnt_reg;
        live_next    = live_reg;
        sel_next     = sel_reg;
        rd_pend_next = 1'b0;
        pix_next     = pix_reg;
        mem_we       = 1'b0;
        mem_waddr    = cnt_reg[AW-1:0];
        mem_wdata    = '0;
        mem_raddr    = cnt_reg[AW-1:0];
        req_valid    = 1'b0;
        req          = pix_reg;

        unique case (state_reg)
            rtf_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == RING_LIM - CW'(1)) begin
                    cnt_next   = '0;
                    state_next = rtf_pkg::ST_IDLE;
                end
            end
            rtf_pkg::ST_IDLE: begin
                if (s_take) begin
                    cnt_next   = '0;
                    live_next  = '0;
                    state_next = rtf_pkg::ST_COUNT;
                end
            end
            rtf_pkg::ST_COUNT: begin
                if (rd_pend_reg && mem_rdata_reg != '0) begin
                    live_next = live_reg + CW'(1);
                end
                if (cnt_reg != ring_count_reg) begin
                    cnt_next     = cnt_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end else if (!rd_pend_reg) begin
                    state_next = rtf_pkg::ST_WAIT_MOD;
                end
            end
            rtf_pkg::ST_WAIT_MOD: begin
                if (mod0_done && mod1_done) begin
                    sel_next   = 1'b0;
                    state_next = rtf_pkg::ST_SPAWN_RD;
                end
            end
            rtf_pkg::ST_SPAWN_RD: begin
                mem_raddr = spawn_idx[AW-1:0];
                if (live_reg < cap) begin
                    state_next = rtf_pkg::ST_SPAWN_WR;
                end else begin
                    cnt_next   = '0;
                    state_next = rtf_pkg::ST_RING_RD;
                end
            end
            rtf_pkg::ST_SPAWN_WR: begin
                mem_waddr = spawn_idx[AW-1:0];
                mem_wdata = rtf_pkg::LIFE_START;
                if (mem_rdata_reg == '0) begin
                    mem_we    = 1'b1;
                    live_next = live_reg + CW'(1);
                end
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = rtf_pkg::ST_SPAWN_RD;
                end else begin
                    cnt_next   = '0;
                    state_next = rtf_pkg::ST_RING_RD;
                end
            end
            rtf_pkg::ST_RING_RD: begin
                state_next = rtf_pkg::ST_RING_CALC;
            end
            rtf_pkg::ST_RING_CALC: begin
                pix_next.pixel_index = ring_pos;
                pix_next.frame_end   = ring_last && (face_count_reg == '0);
                if (mem_rdata_reg > rtf_pkg::WHITE_ABOVE) begin
                    pix_next.red   = rtf_pkg::CHAN_FULL;
                    pix_next.green = rtf_pkg::CHAN_FULL;
                    pix_next.blue  = rtf_pkg::CHAN_FULL;
                end else begin
                    pix_next.red   = '0;
                    pix_next.green = HW'(green_prod >> 2);
                    pix_next.blue  = HW'(blue_prod >> 3);
                end
                if (mem_rdata_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_reg - LW'(1);
                end
                state_next = rtf_pkg::ST_RING_OUT;
            end
            rtf_pkg::ST_RING_OUT: begin
                req_valid = 1'b1;
                if (req_take) begin
                    cnt_next = cnt_reg + CW'(1);
                    if (!ring_last) begin
                        state_next = rtf_pkg::ST_RING_RD;
                    end else if (face_count_reg == '0) begin
                        state_next = rtf_pkg::ST_IDLE;
                    end else begin
                        fcnt_next  = '0;
                        state_next = rtf_pkg::ST_FACE;
                    end
                end
            end
            rtf_pkg::ST_FACE: begin
                req_valid         = 1'b1;
                req.pixel_index   = face_pos;
                req.red           = '0;
                req.green         = '0;
                req.blue          = '0;
                req.frame_end     = face_last;
                if (req_take) begin
                    fcnt_next = fcnt_reg + CW'(1);
                    if (face_last) begin
                        state_next = rtf_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = rtf_pkg::ST_IDLE;
            end
        endcase
    end

    rtf_pixel_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .brightness    (brightness_reg),
        .req_valid     (req_valid),
        .req           (req),
        .req_take      (req_take),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_frame_end   (m_frame_end)
    );

endmodule

// File: rtl/core/rtf_mod_unit.sv
// Bit-serial remainder unit: 32-bit word modulo a 6-bit divisor, one bit a cycle.
// Depends on rtf_pkg.
`timescale 1ns / 1ps

module rtf_mod_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rtf_pkg::RAND_W-1:0] dividend,
    input  logic [rtf_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [rtf_pkg::CNT_W-1:0]  rem
);

    logic [rtf_pkg::RAND_W-1:0] dvd_reg;
    logic [rtf_pkg::CNT_W-1:0]  rem_reg;
    logic [rtf_pkg::CNT_W-1:0]  rem_next;
    logic [rtf_pkg::STEP_W-1:0] step_reg;
    logic                       busy_reg;
    logic [rtf_pkg::CNT_W:0]    shifted;

    always_comb begin
        shifted = {rem_reg, dvd_reg[rtf_pkg::RAND_W-1]};
        if (shifted >= {1'b0, divisor}) begin
            rem_next = rtf_pkg::CNT_W'(shifted - {1'b0, divisor});
        end else begin
            rem_next = shifted[rtf_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= rtf_pkg::STEP_W'(rtf_pkg::RAND_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == rtf_pkg::STEP_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = !busy_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/core/rtf_pixel_out.sv
// Brightness scaling and output register of the result channel.
// Depends on rtf_pkg.
`timescale 1ns / 1ps

module rtf_pixel_out (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [rtf_pkg::CHAN_W-1:0] brightness,
    input  logic                       req_valid,
    input  rtf_pkg::pix_req_t          req,
    output logic                       req_take,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rtf_pkg::CNT_W-1:0]  m_pixel_index,
    output logic [rtf_pkg::CHAN_W-1:0] m_red,
    output logic [rtf_pkg::CHAN_W-1:0] m_green,
    output logic [rtf_pkg::CHAN_W-1:0] m_blue,
    output logic                       m_frame_end
);

    logic                       m_valid_reg;
    logic [rtf_pkg::CNT_W-1:0]  idx_reg;
    logic [rtf_pkg::CHAN_W-1:0] red_reg;
    logic [rtf_pkg::CHAN_W-1:0] green_reg;
    logic [rtf_pkg::CHAN_W-1:0] blue_reg;
    logic                       end_reg;

    // floor(c * b / 255) = (p + 1 + (p >> 8)) >> 8 for p below 2^16
    function automatic logic [rtf_pkg::CHAN_W-1:0] scale(
        input logic [rtf_pkg::CHAN_W-1:0] c,
        input logic [rtf_pkg::CHAN_W-1:0] b
    );
        logic [2*rtf_pkg::CHAN_W-1:0] p;
        logic [2*rtf_pkg::CHAN_W:0]   t;
        p = c * b;
        t = {1'b0, p} + (2*rtf_pkg::CHAN_W+1)'(1) + (2*rtf_pkg::CHAN_W+1)'(p >> 8);
        return t[2*rtf_pkg::CHAN_W-1:rtf_pkg::CHAN_W];
    endfunction

    assign req_take = req_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (req_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            idx_reg   <= req.pixel_index;
            red_reg   <= scale(req.red, brightness);
            green_reg <= scale(req.green, brightness);
            blue_reg  <= scale(req.blue, brightness);
            end_reg   <= req.frame_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_index = idx_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;
    assign m_frame_end   = end_reg;

endmodule
